>>> design/tkf_pkg.sv
// Package with shared constants and functions for the tilt Kalman filter.
`timescale 1ns / 1ps
package tkf_pkg;

  localparam int unsigned ONE_Q16   = 65536;
  localparam int signed   DEG90_Q16 = 5898240;

  localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
  localparam logic [1:0] CFG_PROCESS_NOISE = 2'd1;
  localparam logic [1:0] CFG_MEAS_NOISE    = 2'd2;

  // Arctangent of 2^-i in degrees, Q16.16, rounded to nearest.
  function automatic logic [21:0] atan_tab(input logic [4:0] idx);
    logic [21:0] r;
    begin
      case (idx)
        5'd0:  r = 22'd2949120;
        5'd1:  r = 22'd1740967;
        5'd2:  r = 22'd919879;
        5'd3:  r = 22'd466945;
        5'd4:  r = 22'd234379;
        5'd5:  r = 22'd117304;
        5'd6:  r = 22'd58666;
        5'd7:  r = 22'd29335;
        5'd8:  r = 22'd14668;
        5'd9:  r = 22'd7334;
        5'd10: r = 22'd3667;
        5'd11: r = 22'd1833;
        5'd12: r = 22'd917;
        5'd13: r = 22'd458;
        5'd14: r = 22'd229;
        5'd15: r = 22'd115;
        5'd16: r = 22'd57;
        5'd17: r = 22'd29;
        5'd18: r = 22'd14;
        5'd19: r = 22'd7;
        5'd20: r = 22'd4;
        5'd21: r = 22'd2;
        5'd22: r = 22'd1;
        default: r = 22'd0;
      endcase
      return r;
    end
  endfunction

  // Saturate a 66-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    begin
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else return v[31:0];
    end
  endfunction

endpackage

>>> design/tkf_cordic.sv
// Iterative CORDIC vectoring unit for the accelerometer tilt angle.
`timescale 1ns / 1ps
module tkf_cordic
  import tkf_pkg::*;
#(
  parameter int unsigned Steps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] a_i,
  input  logic signed [15:0] b_i,
  output logic               done_o,
  output logic signed [23:0] angle_o
);

  localparam int unsigned NSteps = (Steps > 32) ? 32 : Steps;

  logic               busy_q, busy_d;
  logic [5:0]         cnt_q, cnt_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [27:0] z_q, z_d;
  logic               done_q, done_d;
  logic signed [23:0] ang_q, ang_d;
  logic signed [33:0] xs, ys;
  logic signed [27:0] t;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    done_d = 1'b0;
    ang_d  = ang_q;
    xs     = x_q >>> cnt_q[4:0];
    ys     = y_q >>> cnt_q[4:0];
    t      = 28'(signed'({1'b0, atan_tab(cnt_q[4:0])}));
    if (start_i) begin
      if (b_i == 16'sd0) begin
        done_d = 1'b1;
        ang_d  = (a_i > 0) ? 24'(DEG90_Q16) : (a_i < 0) ? -24'(DEG90_Q16) : 24'sd0;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        x_d    = 34'((b_i < 0) ? -34'(b_i) : 34'(b_i)) <<< 14;
        y_d    = 34'((b_i < 0) ? -34'(a_i) : 34'(a_i)) <<< 14;
        z_d    = '0;
      end
    end else if (busy_q) begin
      if (cnt_q == 6'(NSteps)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        if (z_q > 28'(DEG90_Q16)) ang_d = 24'(DEG90_Q16);
        else if (z_q < -28'(DEG90_Q16)) ang_d = -24'(DEG90_Q16);
        else ang_d = z_q[23:0];
      end else begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + t;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - t;
        end
        cnt_d = cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    ang_q <= ang_d;
  end

  assign done_o  = done_q;
  assign angle_o = ang_q;

endmodule

>>> design/tkf_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle.
`timescale 1ns / 1ps
module tkf_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic               done_o,
  output logic signed [65:0] p_o
);

  logic               busy_q;
  logic               done_q;
  logic [5:0]         cnt_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] mc_q;
  logic [32:0]        mp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd32) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Top multiplier bit carries negative weight.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= 66'(a_i);
      mp_q  <= b_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        if (cnt_q == 6'd32) acc_q <= acc_q - mc_q;
        else acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

>>> design/tkf_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
`timescale 1ns / 1ps
module tkf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [49:0] n_i,
  input  logic        [33:0] d_i,
  output logic               done_o,
  output logic signed [49:0] q_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [48:0] quo_q;
  logic [33:0] rem_q;
  logic [33:0] den_q;
  logic [34:0] trial;

  assign trial = {rem_q, quo_q[48]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd48) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= n_i[49];
      quo_q <= n_i[49] ? 49'(-n_i) : n_i[48:0];
      rem_q <= '0;
      den_q <= d_i;
    end else if (busy_q) begin
      if (!trial[34]) begin
        rem_q <= trial[33:0];
        quo_q <= {quo_q[47:0], 1'b1};
      end else begin
        rem_q <= {rem_q[32:0], quo_q[48]};
        quo_q <= {quo_q[47:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? -50'(quo_q) : 50'(quo_q);

endmodule

>>> design/tilt_kalman_filter_top.sv
// Top level of the two-state tilt Kalman filter with its sequencer.
// An init item runs the CORDIC, which skips its iterations when accel_b is zero; a filter item
// adds 13 bit-serial products and two divisions, or 5 products when the gains are skipped.
// Throughput: one item at a time, the next transfer in the cycle tvalid rises at the earliest.
// Reset restores the register defaults, clears angle and bias, sets the covariance to identity.
`timescale 1ns / 1ps
module tilt_kalman_filter_top
  import tkf_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item: tuser = func; tdata = accel_a[15:0], accel_b[31:16], gyro_rate[47:32].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  // Result: tdata = angle_estimate[31:0], raw_angle[55:32], bias_estimate[87:56].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CORD  = 4'd1;
  localparam logic [3:0] ST_MSTRT = 4'd2;
  localparam logic [3:0] ST_MWAIT = 4'd3;
  localparam logic [3:0] ST_DSTRT = 4'd4;
  localparam logic [3:0] ST_DWAIT = 4'd5;
  localparam logic [3:0] ST_OUT   = 4'd6;

  // Step codes of the filter program.
  localparam logic [4:0] SP_DTRATE = 5'd0;
  localparam logic [4:0] SP_DP11   = 5'd1;
  localparam logic [4:0] SP_DP10   = 5'd2;
  localparam logic [4:0] SP_DP01   = 5'd3;
  localparam logic [4:0] SP_DDP    = 5'd4;
  localparam logic [4:0] SP_K0     = 5'd5;
  localparam logic [4:0] SP_K1     = 5'd6;
  localparam logic [4:0] SP_KS0    = 5'd7;
  localparam logic [4:0] SP_KS1    = 5'd8;
  localparam logic [4:0] SP_KE0    = 5'd9;
  localparam logic [4:0] SP_KE1    = 5'd10;
  localparam logic [4:0] SP_C00    = 5'd11;
  localparam logic [4:0] SP_C01    = 5'd12;
  localparam logic [4:0] SP_C10    = 5'd13;
  localparam logic [4:0] SP_C11    = 5'd14;

  logic [3:0]  state_q;
  logic [4:0]  step_q;
  logic [23:0] ts_q, pn_q, mn_q;
  logic        func_q;
  logic signed [15:0] g_q;
  logic signed [31:0] ang_st_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  // Working registers.
  logic signed [31:0] ang_q, pp0_q, pp1_q, pp2_q, pp3_q, eps_q;
  logic signed [31:0] k0_q, k1_q, ks0_q, ks1_q;
  logic signed [33:0] s_q;
  logic signed [65:0] t1_q, t2_q, t3_q, dp11_q;
  logic signed [23:0] raw_q;
  logic        ovalid_q;
  logic [87:0] odata_q;

  logic               cord_start, cord_done;
  logic signed [23:0] cord_angle;
  logic               mul_start, mul_done;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p, mul_sh;
  logic               div_start, div_done;
  logic signed [49:0] div_n, div_q;
  logic signed [65:0] sum00;

  // True when the innovation variance is positive.
  function automatic logic s_q_next_pos(input logic signed [65:0] v);
    logic signed [33:0] s;
    begin
      s = 34'(sat32(v)) + 34'(mn_q);
      return s > 0;
    end
  endfunction

  // The CORDIC loads its operands straight from the accepted transfer.
  tkf_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cord_start), .a_i(s_axis_tdata[15:0]),
    .b_i(s_axis_tdata[31:16]), .done_o(cord_done), .angle_o(cord_angle)
  );

  tkf_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  tkf_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .n_i(div_n), .d_i(34'(s_q)),
    .done_o(div_done), .q_o(div_q)
  );

  // The result register parts the two sides, so a waiting result does not
  // hold off the next input transfer.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  assign cord_start = (state_q == ST_IDLE) && s_axis_tvalid && s_axis_tready;
  assign mul_start  = (state_q == ST_MSTRT);
  assign div_start  = (state_q == ST_DSTRT);
  assign div_n      = 50'((step_q == SP_K0) ? pp0_q : pp2_q) <<< 16;

  // Time-step products shift by 24, gain products by 16.
  assign mul_sh = (step_q <= SP_DDP) ? (mul_p >>> 24) : (mul_p >>> 16);
  assign sum00  = 66'(p00_q) - t2_q - t3_q + mul_sh + 66'(pn_q);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = 33'(signed'({1'b0, ts_q}));
    mul_b = '0;
    case (step_q)
      SP_DTRATE: mul_b = 33'(32'(g_q) * 32'sd500) - 33'(bias_q);
      SP_DP11:   mul_b = 33'(p11_q);
      SP_DP10:   mul_b = 33'(p10_q);
      SP_DP01:   mul_b = 33'(p01_q);
      SP_DDP:    mul_b = dp11_q[32:0];
      SP_KS0:    begin mul_a = 33'(k0_q);  mul_b = s_q[32:0]; end
      SP_KS1:    begin mul_a = 33'(k1_q);  mul_b = s_q[32:0]; end
      SP_KE0:    begin mul_a = 33'(k0_q);  mul_b = 33'(eps_q); end
      SP_KE1:    begin mul_a = 33'(k1_q);  mul_b = 33'(eps_q); end
      SP_C00:    begin mul_a = 33'(ks0_q); mul_b = 33'(k0_q); end
      SP_C01:    begin mul_a = 33'(ks0_q); mul_b = 33'(k1_q); end
      SP_C10:    begin mul_a = 33'(ks1_q); mul_b = 33'(k0_q); end
      SP_C11:    begin mul_a = 33'(ks1_q); mul_b = 33'(k1_q); end
      default:   ;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q <= 24'd83886;
      pn_q <= 24'd11796;
      mn_q <= 24'd65536;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TIME_STEP:     ts_q <= cfg_data_i;
        CFG_PROCESS_NOISE: pn_q <= cfg_data_i;
        CFG_MEAS_NOISE:    mn_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  // Input item capture.
  always_ff @(posedge clk_i) begin
    if (cord_start) begin
      func_q <= s_axis_tuser;
      g_q    <= s_axis_tdata[47:32];
    end
  end

  // Datapath working registers, written as each product or quotient lands.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CORD && cord_done) raw_q <= cord_angle;
    if (state_q == ST_MWAIT && mul_done) begin
      case (step_q)
        SP_DTRATE: ang_q  <= sat32(66'(ang_st_q) + mul_sh);
        SP_DP11: begin
          dp11_q <= mul_sh;
          pp1_q  <= sat32(66'(p01_q) - mul_sh);
          pp2_q  <= sat32(66'(p10_q) - mul_sh);
          pp3_q  <= sat32(66'(p11_q) + 66'(pn_q));
        end
        SP_DP10:   t2_q <= mul_sh;
        SP_DP01:   t3_q <= mul_sh;
        SP_DDP: begin
          pp0_q <= sat32(sum00);
          s_q   <= 34'(sat32(sum00)) + 34'(mn_q);
          eps_q <= sat32(66'(raw_q) - 66'(ang_q));
        end
        SP_KS0: ks0_q <= sat32(mul_sh);
        SP_KS1: ks1_q <= sat32(mul_sh);
        SP_KE0: t1_q  <= mul_sh;
        SP_KE1: t2_q  <= mul_sh;
        SP_C00: t3_q  <= mul_sh;
        SP_C01: dp11_q <= mul_sh;
        SP_C10: pp1_q <= sat32(66'(pp1_q) - dp11_q);
        default: ;
      endcase
      if (step_q == SP_C10) begin
        pp0_q <= sat32(66'(pp0_q) - t3_q);
        pp2_q <= sat32(66'(pp2_q) - mul_sh);
      end
    end
    if (state_q == ST_DWAIT && div_done) begin
      if (step_q == SP_K0) k0_q <= sat32(66'(div_q));
      else k1_q <= sat32(66'(div_q));
    end
  end

  // Sequencer and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= SP_DTRATE;
      ovalid_q <= 1'b0;
      ang_st_q <= '0;
      bias_q   <= '0;
      p00_q    <= 32'(ONE_Q16);
      p01_q    <= '0;
      p10_q    <= '0;
      p11_q    <= 32'(ONE_Q16);
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (cord_start) state_q <= ST_CORD;
        ST_CORD: begin
          if (cord_done) begin
            if (!func_q) begin
              ang_st_q <= 32'(cord_angle);
              bias_q   <= '0;
              p00_q    <= 32'(ONE_Q16);
              p01_q    <= '0;
              p10_q    <= '0;
              p11_q    <= 32'(ONE_Q16);
              state_q  <= ST_OUT;
            end else begin
              step_q  <= SP_DTRATE;
              state_q <= ST_MSTRT;
            end
          end
        end
        ST_MSTRT: state_q <= ST_MWAIT;
        ST_MWAIT: begin
          if (mul_done) begin
            if (step_q == SP_DDP) begin
              if (s_q_next_pos(sum00)) begin
                step_q  <= SP_K0;
                state_q <= ST_DSTRT;
              end else begin
                ang_st_q <= ang_q;
                p00_q    <= sat32(sum00);
                p01_q    <= pp1_q;
                p10_q    <= pp2_q;
                p11_q    <= pp3_q;
                state_q  <= ST_OUT;
              end
            end else if (step_q == SP_KE1) begin
              ang_st_q <= sat32(66'(ang_q) + t1_q);
              bias_q   <= sat32(66'(bias_q) + mul_sh);
              step_q   <= SP_C00;
              state_q  <= ST_MSTRT;
            end else if (step_q == SP_C11) begin
              p00_q   <= pp0_q;
              p01_q   <= pp1_q;
              p10_q   <= pp2_q;
              p11_q   <= sat32(66'(pp3_q) - mul_sh);
              state_q <= ST_OUT;
            end else begin
              step_q  <= step_q + 5'd1;
              state_q <= ST_MSTRT;
            end
          end
        end
        ST_DSTRT: state_q <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            if (step_q == SP_K0) begin
              step_q  <= SP_K1;
              state_q <= ST_DSTRT;
            end else begin
              step_q  <= SP_KS0;
              state_q <= ST_MSTRT;
            end
          end
        end
        ST_OUT: begin
          if (!ovalid_q) begin
            ovalid_q <= 1'b1;
            state_q  <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && !ovalid_q) odata_q <= {bias_q, raw_q, ang_st_q};
  end

endmodule

>>> tb/tkf_checker.sv
// Checker for the tilt Kalman filter: predicts every result and compares it.
`timescale 1ns / 1ps
module tkf_checker
  import tkf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [31:0] bias;
    logic signed [23:0] raw;
    logic signed [31:0] angle;
  } tilt_result_t;

  localparam int CORDIC_ITERS = 16;

  logic [23:0] dt_q, noise_q, meas_q;
  longint ang_st, bias_st;
  longint cov [4];
  tilt_result_t result_fifo [$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint atan_step_deg(int i);
    longint tab [23] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
    if (i < 23) return tab[i];
    return 0;
  endfunction

  function automatic longint tilt_from_accel(longint a, longint b);
    longint x, y, z, xn;
    z = 0;
    if (b == 0) return (a > 0) ? DEG90_Q16 : ((a < 0) ? -DEG90_Q16 : 0);
    x = ((b < 0) ? -b : b) * 16384;
    y = ((b < 0) ? -a : a) * 16384;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        y = y - (x >>> i);
        z += atan_step_deg(i);
      end else begin
        xn = x - (y >>> i);
        y = y + (x >>> i);
        z -= atan_step_deg(i);
      end
      x = xn;
    end
    if (z > DEG90_Q16) z = DEG90_Q16;
    if (z < -DEG90_Q16) z = -DEG90_Q16;
    return z;
  endfunction

  function automatic longint times_dt(longint v);
    return (v * longint'(dt_q)) >>> 24;
  endfunction

  task automatic estimate_tilt(logic func, logic [47:0] d);
    longint a, b, g, raw, ang, dp11, s, eps, k0, k1, ks0, ks1, q;
    longint pp [4];
    tilt_result_t r;
    a = longint'($signed(d[15:0]));
    b = longint'($signed(d[31:16]));
    g = longint'($signed(d[47:32]));
    raw = tilt_from_accel(a, b);
    if (!func) begin
      ang_st = raw;
      bias_st = 0;
      cov = '{ONE_Q16, 0, 0, ONE_Q16};
    end else begin
      q = longint'(noise_q);
      ang = clamp32(ang_st + times_dt(g * 500 - bias_st));
      dp11 = times_dt(cov[3]);
      pp[0] = clamp32(cov[0] - times_dt(cov[2]) - times_dt(cov[1]) + times_dt(dp11) + q);
      pp[1] = clamp32(cov[1] - dp11);
      pp[2] = clamp32(cov[2] - dp11);
      pp[3] = clamp32(cov[3] + q);
      s = pp[0] + longint'(meas_q);
      eps = clamp32(raw - ang);
      if (s > 0) begin
        k0 = clamp32((pp[0] * longint'(ONE_Q16)) / s);
        k1 = clamp32((pp[2] * longint'(ONE_Q16)) / s);
        ks0 = clamp32((k0 * s) >>> 16);
        ks1 = clamp32((k1 * s) >>> 16);
        ang_st = clamp32(ang + ((k0 * eps) >>> 16));
        bias_st = clamp32(bias_st + ((k1 * eps) >>> 16));
        cov[0] = clamp32(pp[0] - ((ks0 * k0) >>> 16));
        cov[1] = clamp32(pp[1] - ((ks0 * k1) >>> 16));
        cov[2] = clamp32(pp[2] - ((ks1 * k0) >>> 16));
        cov[3] = clamp32(pp[3] - ((ks1 * k1) >>> 16));
      end else begin
        ang_st = ang;
        cov = pp;
      end
    end
    r.angle = ang_st[31:0];
    r.raw = raw[23:0];
    r.bias = bias_st[31:0];
    result_fifo.push_back(r);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    tilt_result_t got, want;
    if (!rst_ni) begin
      dt_q <= 24'd83886;
      noise_q <= 24'd11796;
      meas_q <= 24'd65536;
      ang_st = 0;
      bias_st = 0;
      cov = '{ONE_Q16, 0, 0, ONE_Q16};
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_TIME_STEP:     dt_q <= cfg_data_i;
          CFG_PROCESS_NOISE: noise_q <= cfg_data_i;
          CFG_MEAS_NOISE:    meas_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) estimate_tilt(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (result_fifo.size() == 0) begin
          report_mismatch("unexpected result", longint'(got.angle), 0);
        end else begin
          want = result_fifo.pop_front();
          if (got.angle !== want.angle)
            report_mismatch("angle_estimate", longint'(got.angle), longint'(want.angle));
          if (got.raw !== want.raw)
            report_mismatch("raw_angle", longint'(got.raw), longint'(want.raw));
          if (got.bias !== want.bias)
            report_mismatch("bias_estimate", longint'(got.bias), longint'(want.bias));
        end
      end
    end
    pending_o = result_fifo.size();
  end

endmodule

>>> tb/tb_tilt_kalman_filter_top.sv
// Testbench top for the tilt Kalman filter: stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_tilt_kalman_filter_top
  import tkf_pkg::*;
;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;
  int          fail_count;
  int          pending;

  tilt_kalman_filter_top dut (.*);

  tkf_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // The receiver follows its own stall pattern: long ready stretches, random
  // stalls, and now and then a longer hold-off.
  initial begin
    int mode;
    forever begin
      @(posedge clk_i);
      mode = $urandom_range(0, 99);
      if (mode < 60) m_axis_tready <= 1'b1;
      else if (mode < 97) m_axis_tready <= 1'($urandom_range(0, 1));
      else m_axis_tready <= 1'b0;
    end
  end

  // Drive one transfer on the input stream; tvalid stays high afterwards until
  // the caller drives the next item or an idle gap.
  task automatic send_item(logic func, logic [15:0] a, logic [15:0] b, logic [15:0] g);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= func;
    s_axis_tdata <= {g, b, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic idle_gap(int cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Block until every predicted result has come back, then let any work the
  // block might still be doing drain out.
  task automatic drain_results();
    idle_gap(1);
    while (pending != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  // One register write, after which the channel goes idle.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] pick_axis();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  // A burst starts with an init transfer most of the time so that the filter
  // runs a well-formed track; the rest are mostly filter steps, with a random operation now and then.
  task automatic random_phase(int count);
    int burst;
    int sent;
    logic [15:0] gyro_base;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 24);
      gyro_base = 16'($urandom);
      for (int i = 0; i < burst && sent < count; i++) begin
        if (i == 0 && $urandom_range(0, 3) != 0)
          send_item(1'b0, pick_axis(), pick_axis(), gyro_base);
        else if ($urandom_range(0, 9) == 0)
          send_item(1'($urandom_range(0, 1)), pick_axis(), pick_axis(), 16'($urandom));
        else
          send_item(1'b1, pick_axis(), pick_axis(),
                    gyro_base + 16'(int'($urandom_range(0, 200)) - 100));
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 40));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part under reset defaults: axis extremes, zero denominator
    // with both signs of the numerator, both axes zero, and filter steps.
    send_item(1'b1, 16'h0000, 16'h0000, 16'h0000);
    send_item(1'b0, 16'h7fff, 16'h0000, 16'h0000);
    send_item(1'b1, 16'h8000, 16'h0000, 16'h7fff);
    send_item(1'b1, 16'h0000, 16'h0000, 16'h8000);
    send_item(1'b0, 16'h8000, 16'h8000, 16'hffff);
    send_item(1'b1, 16'h7fff, 16'h8000, 16'h8000);
    send_item(1'b1, 16'h8000, 16'h7fff, 16'h7fff);
    send_item(1'b1, 16'h7fff, 16'h7fff, 16'h5555);
    send_item(1'b0, 16'h0001, 16'hffff, 16'haaaa);
    send_item(1'b1, 16'hffff, 16'h0001, 16'h0001);
    // The sender holds off until every outstanding result has come back.
    drain_results();

    // Zero time step and zero process noise: no motion, noise term is nil.
    write_reg(CFG_TIME_STEP, 24'd0);
    write_reg(CFG_PROCESS_NOISE, 24'd0);
    write_reg(CFG_MEAS_NOISE, 24'd1);
    send_item(1'b0, 16'h1234, 16'h4321, 16'h0100);
    send_item(1'b1, 16'h8000, 16'h0001, 16'h7fff);
    send_item(1'b1, 16'h7fff, 16'hffff, 16'h8000);
    drain_results();

    // Largest register values to drive the saturating paths.
    write_reg(CFG_TIME_STEP, 24'hffffff);
    write_reg(CFG_PROCESS_NOISE, 24'hffffff);
    write_reg(CFG_MEAS_NOISE, 24'hffffff);
    for (int i = 0; i < 8; i++)
      send_item(1'b1, (i % 2) ? 16'h7fff : 16'h8000, 16'h0001, (i % 2) ? 16'h8000 : 16'h7fff);
    drain_results();

    // Random part over several register settings.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_TIME_STEP, 24'd83886);
          write_reg(CFG_PROCESS_NOISE, 24'd11796);
          write_reg(CFG_MEAS_NOISE, 24'd65536);
        end
        1: begin
          write_reg(CFG_TIME_STEP, 24'd1);
          write_reg(CFG_PROCESS_NOISE, 24'd0);
          write_reg(CFG_MEAS_NOISE, 24'd1);
        end
        default: begin
          write_reg(CFG_TIME_STEP, 24'($urandom));
          write_reg(CFG_PROCESS_NOISE, 24'($urandom));
          write_reg(CFG_MEAS_NOISE, 24'($urandom_range(1, 24'hffffff)));
        end
      endcase
      random_phase(205);
      drain_results();
    end

    if (fail_count == 0) begin
      $display("tilt_kalman_filter_top verification clean");
    end else begin
      $display("tilt_kalman_filter_top verification failed");
    end
    $finish;
  end

  // Watchdog: about 1250 items plus stalls, gaps and
  // drains come to roughly 3 ms; the limit leaves several times that.
  initial begin
    #20ms;
    $display("tilt_kalman_filter_top verification failed");
    $finish;
  end

endmodule
